### rtl/sdalu_pkg.sv
package sdalu_pkg;

    localparam int unsigned DATA_W    = 64;
    localparam int unsigned CMD_W     = 3;
    localparam int unsigned ORDER_W   = 2;
    localparam int unsigned DVD_W     = 2 * DATA_W;
    localparam int unsigned DIV_STEPS = DVD_W;
    localparam int unsigned SCALE_W   = 14;

    localparam logic [SCALE_W-1:0] SCALE      = 14'd10000;
    localparam logic [DATA_W-1:0]  HALF       = 64'd5000;
    localparam logic [DATA_W-1:0]  ROUND_MAX  = 64'd922337203685477;
    localparam logic [DATA_W-1:0]  SMAX       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0]  SMIN       = 64'h8000_0000_0000_0000;

    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CMP   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ROUND = 3'd5;

    localparam logic [ORDER_W-1:0] ORD_LESS    = 2'd0;
    localparam logic [ORDER_W-1:0] ORD_EQUAL   = 2'd1;
    localparam logic [ORDER_W-1:0] ORD_GREATER = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [ORDER_W-1:0]       order;
        logic                     overflow;
        logic                     divide_by_zero;
    } out_item_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic               neg;
        logic [DATA_W-1:0]  value;
        logic [ORDER_W-1:0] order;
        logic               ovf;
        logic               dz;
    } side_t;

    typedef struct packed {
        logic [DVD_W-1:0]  dvd;
        logic [DATA_W-1:0] dsr;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
        logic              qhi;
        side_t             side;
    } cell_t;

endpackage

### rtl/scaled_decimal_alu_core.sv
// Signed decimal fixed-point unit (values scaled by 10000) that takes one item every cycle
// while its output buffer is not full and returns one result per item, in order: three
// front stages (operand magnitudes, partial products, dividend select), a row of 128
// restoring-division cells that each produce one quotient bit and pass the partial remainder
// on, and two closing stages for sign, saturation and rounding. Multiply, divide and round
// all go through the same cell row; add, subtract and compare ride along with their items.
// A two-entry output buffer lets the pipeline keep moving while one result waits.
module scaled_decimal_alu_core import sdalu_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      en;
    logic      cv [0:DIV_STEPS];
    cell_t     cd [0:DIV_STEPS];
    logic      bk_valid;
    out_item_t bk_item;
    out_item_t buf_reg [0:1];
    logic [1:0] count_reg;
    logic      push, pop;

    assign en      = (count_reg != 2'd2);
    assign s_ready = en;

    sdalu_front u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid), .in_item(s_item),
        .out_valid(cv[0]), .out_cell(cd[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
        sdalu_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(cv[i]), .in_cell(cd[i]),
            .out_valid(cv[i+1]), .out_cell(cd[i+1])
        );
    end

    sdalu_back u_back (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(cv[DIV_STEPS]), .in_cell(cd[DIV_STEPS]),
        .out_valid(bk_valid), .out_item(bk_item)
    );

    assign push = en && bk_valid;
    assign pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            buf_reg[0] <= buf_reg[1];
            if (push && count_reg == 2'd1) begin
                buf_reg[0] <= bk_item;
            end
            if (push && count_reg == 2'd2) begin
                buf_reg[1] <= bk_item;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                buf_reg[0] <= bk_item;
            end else begin
                buf_reg[1] <= bk_item;
            end
        end
    end

    assign m_valid = (count_reg != 2'd0);
    assign m_item  = buf_reg[0];

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3) else $error("output buffer count out of range");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == 2'd2 |-> !push) else $error("push into full output buffer");

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.divide_by_zero |-> m_item.value == '0 && !m_item.overflow)
        else $error("divide by zero result not clean");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(cv[DIV_STEPS])) else $error("pipeline moved while stalled");

endmodule

### rtl/sdalu_front.sv
module sdalu_front import sdalu_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  in_item_t in_item,
    output logic     out_valid,
    output cell_t    out_cell
);

    logic [DATA_W-1:0] a_u, b_u, ma, mb, sum, diff;
    side_t             side;

    logic              v1_reg, v2_reg, v3_reg;
    logic [CMD_W-1:0]  cmd1_reg, cmd2_reg;
    logic [DATA_W-1:0] ma1_reg, mb1_reg, ma2_reg, mb2_reg;
    side_t             side1_reg, side2_reg;
    logic [DATA_W-1:0] pll_reg, plh_reg, phl_reg, phh_reg;
    logic [DATA_W+SCALE_W-1:0] pdiv_reg;
    cell_t             cell_reg;

    logic [DATA_W:0]   mid;
    logic [DVD_W-1:0]  prod;

    function automatic cell_t cell_reg_next();
        cell_t c;
        c      = '0;
        c.side = side2_reg;
        if (cmd2_reg == CMD_MUL) begin
            c.dvd = prod;
            c.dsr = DATA_W'(SCALE);
        end else if (cmd2_reg == CMD_DIV) begin
            c.dvd = DVD_W'(pdiv_reg);
            c.dsr = mb2_reg;
        end else begin
            c.dvd = DVD_W'(ma2_reg);
            c.dsr = DATA_W'(SCALE);
        end
        return c;
    endfunction

    always_comb begin
        a_u  = DATA_W'(in_item.operand_a);
        b_u  = DATA_W'(in_item.operand_b);
        ma   = a_u[DATA_W-1] ? (~a_u + 1'b1) : a_u;
        mb   = b_u[DATA_W-1] ? (~b_u + 1'b1) : b_u;
        sum  = a_u + b_u;
        diff = a_u - b_u;
        side       = '0;
        side.cmd   = in_item.cmd;
        side.neg   = a_u[DATA_W-1] ^ b_u[DATA_W-1];
        unique case (in_item.cmd)
            CMD_ADD: begin
                side.value = sum;
                if (a_u[DATA_W-1] == b_u[DATA_W-1] && sum[DATA_W-1] != a_u[DATA_W-1]) begin
                    side.ovf   = 1'b1;
                    side.value = a_u[DATA_W-1] ? SMIN : SMAX;
                end
            end
            CMD_SUB: begin
                side.value = diff;
                if (a_u[DATA_W-1] != b_u[DATA_W-1] && diff[DATA_W-1] != a_u[DATA_W-1]) begin
                    side.ovf   = 1'b1;
                    side.value = a_u[DATA_W-1] ? SMIN : SMAX;
                end
            end
            CMD_DIV: begin
                side.dz = (b_u == '0);
            end
            CMD_CMP: begin
                if (in_item.operand_a < in_item.operand_b) begin
                    side.order = ORD_LESS;
                end else if (in_item.operand_a == in_item.operand_b) begin
                    side.order = ORD_EQUAL;
                end else begin
                    side.order = ORD_GREATER;
                end
            end
            CMD_ROUND: begin
                side.neg = a_u[DATA_W-1];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb begin
        mid  = {1'b0, plh_reg} + {1'b0, phl_reg};
        prod = {phh_reg, pll_reg} + {31'd0, mid, 32'd0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd1_reg  <= in_item.cmd;
            ma1_reg   <= ma;
            mb1_reg   <= mb;
            side1_reg <= side;
            cmd2_reg  <= cmd1_reg;
            ma2_reg   <= ma1_reg;
            mb2_reg   <= mb1_reg;
            side2_reg <= side1_reg;
            pll_reg   <= ma1_reg[31:0]  * mb1_reg[31:0];
            plh_reg   <= ma1_reg[31:0]  * mb1_reg[63:32];
            phl_reg   <= ma1_reg[63:32] * mb1_reg[31:0];
            phh_reg   <= ma1_reg[63:32] * mb1_reg[63:32];
            pdiv_reg  <= ma1_reg * SCALE;
            cell_reg  <= cell_reg_next();
        end
    end

    assign out_valid = v3_reg;
    assign out_cell  = cell_reg;

endmodule

### rtl/sdalu_cell.sv
module sdalu_cell import sdalu_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  cell_t in_cell,
    output logic  out_valid,
    output cell_t out_cell
);

    logic        valid_reg;
    cell_t       cell_reg, cell_next;
    logic [DATA_W-1:0] rem_sh;
    logic        take;

    always_comb begin
        rem_sh    = {in_cell.rem[DATA_W-2:0], in_cell.dvd[DVD_W-1]};
        take      = (rem_sh >= in_cell.dsr);
        cell_next = in_cell;
        cell_next.dvd = {in_cell.dvd[DVD_W-2:0], 1'b0};
        cell_next.rem = take ? (rem_sh - in_cell.dsr) : rem_sh;
        cell_next.quo = {in_cell.quo[DATA_W-2:0], take};
        cell_next.qhi = in_cell.qhi | in_cell.quo[DATA_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

### rtl/sdalu_back.sv
module sdalu_back import sdalu_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  cell_t     in_cell,
    output logic      out_valid,
    output out_item_t out_item
);

    logic              v1_reg, v2_reg;
    side_t             side1_reg, side_next;
    logic [DATA_W-1:0] whole_reg, whole_next;
    out_item_t         item_reg;
    logic              inc;

    always_comb begin
        side_next  = in_cell.side;
        whole_next = '0;
        inc        = !in_cell.side.neg && (in_cell.rem > HALF);
        case (in_cell.side.cmd)
            CMD_MUL, CMD_DIV: begin
                if (in_cell.side.dz) begin
                    side_next.value = '0;
                end else if (in_cell.side.neg) begin
                    if (in_cell.qhi || in_cell.quo > SMIN) begin
                        side_next.ovf   = 1'b1;
                        side_next.value = SMIN;
                    end else begin
                        side_next.value = ~in_cell.quo + 1'b1;
                    end
                end else begin
                    if (in_cell.qhi || in_cell.quo[DATA_W-1]) begin
                        side_next.ovf   = 1'b1;
                        side_next.value = SMAX;
                    end else begin
                        side_next.value = in_cell.quo;
                    end
                end
            end
            CMD_ROUND: begin
                if (in_cell.side.neg) begin
                    whole_next = ~in_cell.quo + 1'b1;
                end else begin
                    whole_next = in_cell.quo + DATA_W'(inc);
                    if (whole_next > ROUND_MAX) begin
                        side_next.ovf   = 1'b1;
                        side_next.value = SMAX;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= side_next;
            whole_reg <= whole_next;
            item_reg.order          <= side1_reg.order;
            item_reg.overflow       <= side1_reg.ovf;
            item_reg.divide_by_zero <= side1_reg.dz;
            if (side1_reg.cmd == CMD_ROUND && !side1_reg.ovf) begin
                item_reg.value <= DATA_W'(whole_reg * SCALE);
            end else begin
                item_reg.value <= side1_reg.value;
            end
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

endmodule
